### design/pid_controller_with_options_defines.svh
// Assertion macros used by the checker file of the PID controller.
`ifndef PID_CONTROLLER_WITH_OPTIONS_DEFINES_SVH
`define PID_CONTROLLER_WITH_OPTIONS_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define PIDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define PIDC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pidc_pkg.sv
// Package: shared types, register indexes and helper functions of the PID controller.
`timescale 1ns / 1ps
`default_nettype none
package pidc_pkg;

	localparam int STALL_LIMIT = 500;
	localparam int CNT_W = 10;

	localparam logic [2:0] REG_GAIN_P = 3'd0;
	localparam logic [2:0] REG_GAIN_I = 3'd1;
	localparam logic [2:0] REG_GAIN_D = 3'd2;
	localparam logic [2:0] REG_OUT_LIM = 3'd3;
	localparam logic [2:0] REG_INT_LIM = 3'd4;
	localparam logic [2:0] REG_RATE_BAND = 3'd5;
	localparam logic [2:0] REG_FILT_TIME = 3'd6;
	localparam logic [2:0] REG_OPT_MASK = 3'd7;

	localparam int OPT_STALL = 0;
	localparam int OPT_TRAP = 1;
	localparam int OPT_VRATE = 2;
	localparam int OPT_DMEAS = 3;
	localparam int OPT_DFILT = 4;
	localparam int OPT_ILIM = 5;
	localparam int OPT_OFILT = 6;

	localparam logic ALU_MUL = 1'b0;
	localparam logic ALU_DIV = 1'b1;

	typedef struct packed {
		logic start;
		logic op;
		logic [63:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] res;
	} alu_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [31:0] r;
		if (x > 66'sh7FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (x < -66'sh80000000)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		logic [63:0] r;
		if (x[63])
			r = 64'(-x);
		else
			r = 64'(x);
		return r;
	endfunction

	function automatic logic same_sign(input logic signed [31:0] a, input logic signed [31:0] b);
		return (!a[31] && a != 0 && !b[31] && b != 0) || (a[31] && b[31]);
	endfunction

endpackage
`default_nettype wire

### design/pidc_alu.sv
// Shared bit-serial multiply and restoring divide unit on unsigned magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module pidc_alu (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pidc_pkg::alu_req_t req,
	output pidc_pkg::alu_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic op_q;
	logic [6:0] cnt_q;
	logic [63:0] acc_q;
	logic [63:0] a_q;
	logic [31:0] b_q;
	logic [31:0] rem_q;
	logic [32:0] rem_n;

	assign rem_n = {rem_q, a_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= pidc_pkg::ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= (req.op == pidc_pkg::ALU_DIV) ? 7'd64 : 7'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == pidc_pkg::ALU_MUL) begin
				if (b_q[0])
					acc_q <= acc_q + a_q;
				a_q <= {a_q[62:0], 1'b0};
				b_q <= {1'b0, b_q[31:1]};
			end else if (rem_n >= {1'b0, b_q}) begin
				rem_q <= 32'(rem_n - {1'b0, b_q});
				a_q <= {a_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_n[31:0];
				a_q <= {a_q[62:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, res: ((op_q == pidc_pkg::ALU_MUL) ? acc_q : a_q)};

endmodule
`default_nettype wire

### design/pid_controller_with_options.sv
// PID controller top level: configuration registers, step sequencer and state.
// The work of one item runs on the shared bit-serial unit, one multiply or
// divide at a time; four multiplies and one divide are always needed, and
// variable rate and each low-pass filter add further multiplies and a divide.
// The input is ready whenever the sequencer is idle, even while a result
// waits on the output.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_with_options (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [79:0] s_tdata,     // measured[31:0], setpoint[63:32], step_time[79:64]
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [39:0] m_tdata,          // drive[31:0], stalled[32], zero[39:33]
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_PRE = 5'd1;
	localparam logic [4:0] ST_P = 5'd2;
	localparam logic [4:0] ST_I1 = 5'd3;
	localparam logic [4:0] ST_I2 = 5'd4;
	localparam logic [4:0] ST_D1 = 5'd5;
	localparam logic [4:0] ST_D2 = 5'd6;
	localparam logic [4:0] ST_VR = 5'd7;
	localparam logic [4:0] ST_V1 = 5'd8;
	localparam logic [4:0] ST_V2 = 5'd9;
	localparam logic [4:0] ST_FD = 5'd10;
	localparam logic [4:0] ST_F1 = 5'd11;
	localparam logic [4:0] ST_F2 = 5'd12;
	localparam logic [4:0] ST_F3 = 5'd13;
	localparam logic [4:0] ST_F4 = 5'd14;
	localparam logic [4:0] ST_AW = 5'd15;
	localparam logic [4:0] ST_SUM = 5'd16;
	localparam logic [4:0] ST_FO = 5'd17;
	localparam logic [4:0] ST_O1 = 5'd18;
	localparam logic [4:0] ST_O2 = 5'd19;
	localparam logic [4:0] ST_O3 = 5'd20;
	localparam logic [4:0] ST_O4 = 5'd21;
	localparam logic [4:0] ST_FIN = 5'd22;

	logic signed [31:0] kp_q, ki_q, kd_q;
	logic [30:0] maxo_q, ilim_q;
	logic [31:0] band_q, filt_q;
	logic [6:0] opt_q;

	logic [4:0] state_q;
	logic signed [31:0] meas_q, sp_q;
	logic [15:0] dt_q;
	logic signed [31:0] err_q, pout_q, iterm_q, dout_q, outv_q;
	logic signed [63:0] lp_q;
	logic neg_q;

	logic signed [31:0] isum_q, prev_err_q, prev_meas_q, prev_sp_q, prev_dterm_q, prev_drive_q;
	logic [pidc_pkg::CNT_W-1:0] stall_cnt_q;
	logic stall_flag_q;

	logic m_valid_q;
	logic [39:0] m_data_q;

	pidc_pkg::alu_req_t req_q;
	pidc_pkg::alu_rsp_t rsp;

	pidc_alu u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_q),
		.rsp(rsp)
	);

	// step arithmetic
	logic signed [63:0] prod_s;
	logic signed [31:0] err_c, base_c, diff_c;
	logic [63:0] err_mag;
	logic [23:0] band_a, band_b;
	logic [24:0] band_ab;
	logic vr_cond, vr_scale;

	// stall detection
	logic signed [42:0] pd1000;
	logic [63:0] aref64, dev64;
	logic stall_skip, stall_hit;
	logic [pidc_pkg::CNT_W-1:0] cnt_n;
	logic flag_n;

	// anti-windup and output sum
	logic signed [33:0] tmp_i;
	logic signed [34:0] tmp_o, abs_o;
	logic signed [31:0] aw_iterm, aw_isum, isum_n, outv_c, clamp_c;

	always_comb begin
		prod_s = neg_q ? -$signed(rsp.res) : $signed(rsp.res);
		err_c = pidc_pkg::sat32(66'(sp_q) - 66'(meas_q));
		if (opt_q[pidc_pkg::OPT_TRAP])
			base_c = 32'((34'(err_q) + 34'(prev_err_q)) >>> 1);
		else
			base_c = err_q;
		if (opt_q[pidc_pkg::OPT_DMEAS])
			diff_c = pidc_pkg::sat32(66'(prev_meas_q) - 66'(meas_q));
		else
			diff_c = pidc_pkg::sat32(66'(err_q) - 66'(prev_err_q));
		err_mag = pidc_pkg::mag64(64'(err_q));
		band_a = {band_q[31:16], 8'd0};
		band_b = {band_q[15:0], 8'd0};
		band_ab = 25'(band_a) + 25'(band_b);
		vr_cond = opt_q[pidc_pkg::OPT_VRATE] && pidc_pkg::same_sign(err_q, isum_q)
			&& (err_mag[32:0] > 33'(band_b));
		vr_scale = (err_mag[32:0] <= 33'(band_ab)) && (band_a != 24'd0);
	end

	always_comb begin
		pd1000 = 43'(prev_drive_q) * 43'sd1000;
		aref64 = pidc_pkg::mag64(64'(prev_sp_q));
		dev64 = pidc_pkg::mag64(64'(prev_sp_q) - 64'(prev_meas_q));
		stall_skip = (pd1000 < $signed({12'd0, maxo_q})) || (aref64 <= 64'd6);
		stall_hit = (40'(dev64[32:0]) * 40'd20) > (40'(aref64[31:0]) * 40'd19);
		cnt_n = stall_cnt_q;
		flag_n = stall_flag_q;
		if (opt_q[pidc_pkg::OPT_STALL] && !stall_skip) begin
			if (stall_hit) begin
				if (stall_cnt_q != {pidc_pkg::CNT_W{1'b1}})
					cnt_n = stall_cnt_q + 1'b1;
			end else begin
				cnt_n = '0;
			end
			if (cnt_n > pidc_pkg::CNT_W'(pidc_pkg::STALL_LIMIT))
				flag_n = 1'b1;
		end
	end

	always_comb begin
		tmp_i = 34'(isum_q) + 34'(iterm_q);
		tmp_o = 35'(pout_q) + 35'(isum_q) + 35'(dout_q);
		abs_o = tmp_o[34] ? -tmp_o : tmp_o;
		aw_iterm = iterm_q;
		aw_isum = isum_q;
		if (opt_q[pidc_pkg::OPT_ILIM]) begin
			if (abs_o > $signed({4'd0, maxo_q}) && pidc_pkg::same_sign(err_q, isum_q))
				aw_iterm = '0;
			if (tmp_i > $signed({3'd0, ilim_q})) begin
				aw_iterm = '0;
				aw_isum = $signed({1'b0, ilim_q});
			end
			if (tmp_i < -$signed({3'd0, ilim_q})) begin
				aw_iterm = '0;
				aw_isum = 32'(-$signed({1'b0, ilim_q}));
			end
		end
		isum_n = pidc_pkg::sat32(66'(isum_q) + 66'(iterm_q));
		outv_c = pidc_pkg::sat32(66'(pout_q) + 66'(isum_n) + 66'(dout_q));
		if (outv_q > $signed({2'd0, maxo_q}))
			clamp_c = $signed({1'b0, maxo_q});
		else if (outv_q < -$signed({2'd0, maxo_q}))
			clamp_c = 32'(-$signed({1'b0, maxo_q}));
		else
			clamp_c = outv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			maxo_q <= '0;
			ilim_q <= '0;
			band_q <= '0;
			filt_q <= '0;
			opt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pidc_pkg::REG_GAIN_P: kp_q <= cfg_wdata;
				pidc_pkg::REG_GAIN_I: ki_q <= cfg_wdata;
				pidc_pkg::REG_GAIN_D: kd_q <= cfg_wdata;
				pidc_pkg::REG_OUT_LIM: maxo_q <= cfg_wdata[30:0];
				pidc_pkg::REG_INT_LIM: ilim_q <= cfg_wdata[30:0];
				pidc_pkg::REG_RATE_BAND: band_q <= cfg_wdata;
				pidc_pkg::REG_FILT_TIME: filt_q <= cfg_wdata;
				pidc_pkg::REG_OPT_MASK: opt_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q <= '0;
			neg_q <= 1'b0;
			isum_q <= '0;
			prev_err_q <= '0;
			prev_meas_q <= '0;
			prev_sp_q <= '0;
			prev_dterm_q <= '0;
			prev_drive_q <= '0;
			stall_cnt_q <= '0;
			stall_flag_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					req_q.start <= 1'b0;
					if (s_tvalid)
						state_q <= ST_PRE;
				end
				ST_PRE: begin
					stall_cnt_q <= cnt_n;
					stall_flag_q <= flag_n;
					err_q <= err_c;
					req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(64'(err_c)),
						32'(pidc_pkg::mag64(64'(kp_q)))};
					neg_q <= err_c[31] ^ kp_q[31];
					state_q <= ST_P;
				end
				ST_P: if (rsp.done) begin
					pout_q <= pidc_pkg::sat32(66'(prod_s >>> 16));
					req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(64'(base_c)),
						32'(pidc_pkg::mag64(64'(ki_q)))};
					neg_q <= base_c[31] ^ ki_q[31];
					state_q <= ST_I1;
				end else begin
					req_q.start <= 1'b0;
				end
				ST_I1: if (rsp.done) begin
					req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(prod_s >>> 16),
						{16'd0, dt_q}};
					neg_q <= prod_s[63];
					state_q <= ST_I2;
				end else begin
					req_q.start <= 1'b0;
				end
				ST_I2: if (rsp.done) begin
					iterm_q <= pidc_pkg::sat32(66'(prod_s >>> 16));
					req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(64'(diff_c)),
						32'(pidc_pkg::mag64(64'(kd_q)))};
					neg_q <= diff_c[31] ^ kd_q[31];
					state_q <= ST_D1;
				end else begin
					req_q.start <= 1'b0;
				end
				ST_D1: if (rsp.done) begin
					req_q <= '{1'b1, pidc_pkg::ALU_DIV, rsp.res, {16'd0, dt_q}};
					state_q <= ST_D2;
				end else begin
					req_q.start <= 1'b0;
				end
				ST_D2: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						dout_q <= pidc_pkg::sat32(66'(prod_s));
						state_q <= ST_VR;
					end
				end
				ST_VR: begin
					if (vr_cond && vr_scale) begin
						req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(64'(iterm_q)),
							32'(33'(band_ab) - err_mag[32:0])};
						neg_q <= iterm_q[31];
						state_q <= ST_V1;
					end else begin
						req_q.start <= 1'b0;
						if (vr_cond)
							iterm_q <= '0;
						state_q <= ST_FD;
					end
				end
				ST_V1: if (rsp.done) begin
					req_q <= '{1'b1, pidc_pkg::ALU_DIV, rsp.res, {8'd0, band_a}};
					state_q <= ST_V2;
				end else begin
					req_q.start <= 1'b0;
				end
				ST_V2: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						iterm_q <= 32'(prod_s);
						state_q <= ST_FD;
					end
				end
				ST_FD: begin
					if (opt_q[pidc_pkg::OPT_DFILT]) begin
						req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(64'(dout_q)),
							{16'd0, dt_q}};
						neg_q <= dout_q[31];
						state_q <= ST_F1;
					end else begin
						req_q.start <= 1'b0;
						state_q <= ST_AW;
					end
				end
				ST_F1: if (rsp.done) begin
					lp_q <= prod_s;
					req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(64'(prev_dterm_q)),
						{16'd0, filt_q[15:0]}};
					neg_q <= prev_dterm_q[31];
					state_q <= ST_F2;
				end else begin
					req_q.start <= 1'b0;
				end
				ST_F2: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						lp_q <= lp_q + prod_s;
						state_q <= ST_F3;
					end
				end
				ST_F3: begin
					req_q <= '{1'b1, pidc_pkg::ALU_DIV, pidc_pkg::mag64(lp_q),
						32'(17'(filt_q[15:0]) + 17'(dt_q))};
					neg_q <= lp_q[63];
					state_q <= ST_F4;
				end
				ST_F4: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						dout_q <= pidc_pkg::sat32(66'(prod_s));
						state_q <= ST_AW;
					end
				end
				ST_AW: begin
					req_q.start <= 1'b0;
					iterm_q <= aw_iterm;
					isum_q <= aw_isum;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					req_q.start <= 1'b0;
					isum_q <= isum_n;
					outv_q <= outv_c;
					prev_dterm_q <= dout_q;
					state_q <= ST_FO;
				end
				ST_FO: begin
					if (opt_q[pidc_pkg::OPT_OFILT]) begin
						req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(64'(outv_q)),
							{16'd0, dt_q}};
						neg_q <= outv_q[31];
						state_q <= ST_O1;
					end else begin
						req_q.start <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_O1: if (rsp.done) begin
					lp_q <= prod_s;
					req_q <= '{1'b1, pidc_pkg::ALU_MUL, pidc_pkg::mag64(64'(prev_drive_q)),
						{16'd0, filt_q[31:16]}};
					neg_q <= prev_drive_q[31];
					state_q <= ST_O2;
				end else begin
					req_q.start <= 1'b0;
				end
				ST_O2: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						lp_q <= lp_q + prod_s;
						state_q <= ST_O3;
					end
				end
				ST_O3: begin
					req_q <= '{1'b1, pidc_pkg::ALU_DIV, pidc_pkg::mag64(lp_q),
						32'(17'(filt_q[31:16]) + 17'(dt_q))};
					neg_q <= lp_q[63];
					state_q <= ST_O4;
				end
				ST_O4: begin
					req_q.start <= 1'b0;
					if (rsp.done) begin
						outv_q <= pidc_pkg::sat32(66'(prod_s));
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					req_q.start <= 1'b0;
					if (!m_valid_q || m_tready) begin
						prev_drive_q <= clamp_c;
						prev_err_q <= err_q;
						prev_meas_q <= meas_q;
						prev_sp_q <= sp_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					req_q.start <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!m_valid_q || m_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			meas_q <= s_tdata[31:0];
			sp_q <= s_tdata[63:32];
			dt_q <= (s_tdata[79:64] == 16'd0) ? 16'd1 : s_tdata[79:64];
		end
		if (state_q == ST_FIN && (!m_valid_q || m_tready))
			m_data_q <= {7'd0, stall_flag_q, clamp_c};
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

endmodule
`default_nettype wire

### design/pidc_checker.sv
// Port-level checker for the PID controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_controller_with_options_defines.svh"
module pidc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [79:0] s_tdata,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_wdata
);

	logic [1:0] pend_q;
	logic seen_stall_q;
	logic in_acc, out_acc;

	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			seen_stall_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc && m_tdata[32])
				seen_stall_q <= 1'b1;
		end
	end

	`PIDC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
	`PIDC_ASSERT_NOW(a_no_invented, m_tvalid, pend_q != 2'd0, "result without a pending transaction")
	`PIDC_ASSERT_NXT(a_busy_after_accept, in_acc, !s_tready, "input ready right after accept")
	`PIDC_ASSERT_NOW(a_stall_sticky, m_tvalid && seen_stall_q, m_tdata[32], "stall flag cleared")

endmodule

bind pid_controller_with_options pidc_checker u_pidc_checker (.*);
`default_nettype wire
